/* hw/rtl/tun_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Widths and the per-stage word type shared by the face normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int RAW_WIDTH   = 2 * DIFF_WIDTH;
    localparam int MAG_WIDTH   = RAW_WIDTH - 1;
    localparam int SUM_WIDTH   = 2 * MAG_WIDTH + 2;
    localparam int LEN_WIDTH   = SUM_WIDTH / 2;
    localparam int Q_WIDTH     = FRAC_BITS + 1;
    localparam int UNIT_WIDTH  = 16;
    localparam int THR_WIDTH   = 32;

    typedef logic signed [RAW_WIDTH-1:0] raw_t;

    typedef struct packed {
        raw_t                 raw_x;
        raw_t                 raw_y;
        raw_t                 raw_z;
        logic [MAG_WIDTH-1:0] mag_x;
        logic [MAG_WIDTH-1:0] mag_y;
        logic [MAG_WIDTH-1:0] mag_z;
    } vec_t;
endpackage

/* hw/rtl/tun_pipe_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pipe_sqrt
// Pipelined integer square root, one result bit per stage, stall-aware.
// Carries the vector word alongside so results stay aligned.
// ----------------------------------------------------------------------------
module tun_pipe_sqrt
    import tun_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SUM_WIDTH-1:0] in_sum,
    input  vec_t                 in_vec,
    output logic                 out_valid,
    output logic [LEN_WIDTH-1:0] out_len,
    output vec_t                 out_vec
);
    // restoring method: remainder, root, remaining radicand bits
    logic [LEN_WIDTH+1:0] rem_reg  [LEN_WIDTH];
    logic [LEN_WIDTH-1:0] root_reg [LEN_WIDTH];
    logic [SUM_WIDTH-1:0] rad_reg  [LEN_WIDTH];
    vec_t                 vec_reg  [LEN_WIDTH];
    logic [LEN_WIDTH-1:0] vld_reg;

    genvar g;
    generate
        for (g = 0; g < LEN_WIDTH; g++) begin : g_stage
            logic [LEN_WIDTH+1:0] rem_in, trial, rem_next;
            logic [LEN_WIDTH-1:0] root_in, root_next;
            logic [SUM_WIDTH-1:0] rad_in;
            logic                 v_in;
            vec_t                 vec_in;
            if (g == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = in_sum;
                assign v_in    = in_valid;
                assign vec_in  = in_vec;
            end else begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign rad_in  = rad_reg[g-1];
                assign v_in    = vld_reg[g-1];
                assign vec_in  = vec_reg[g-1];
            end
            always_comb begin
                rem_next  = {rem_in[LEN_WIDTH-1:0], rad_in[SUM_WIDTH-1 -: 2]};
                trial     = {root_in, 2'b01};
                root_next = {root_in[LEN_WIDTH-2:0], 1'b0};
                if (rem_next >= trial) begin
                    rem_next  = rem_next - trial;
                    root_next[0] = 1'b1;
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= v_in;
                end
                if (en) begin
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= root_next;
                    rad_reg[g]  <= {rad_in[SUM_WIDTH-3:0], 2'b00};
                    vec_reg[g]  <= vec_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[LEN_WIDTH-1];
    assign out_len   = root_reg[LEN_WIDTH-1];
    assign out_vec   = vec_reg[LEN_WIDTH-1];
endmodule

/* hw/rtl/tun_pipe_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pipe_div
// Pipelined restoring divider for the three scaled components,
// one quotient bit per stage for all lanes.
// ----------------------------------------------------------------------------
module tun_pipe_div
    import tun_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [LEN_WIDTH-1:0]  in_len,
    input  logic                  in_degen,
    input  vec_t                  in_vec,
    output logic                  out_valid,
    output logic                  out_degen,
    output vec_t                  out_vec,
    output logic [Q_WIDTH-1:0]    out_qx,
    output logic [Q_WIDTH-1:0]    out_qy,
    output logic [Q_WIDTH-1:0]    out_qz
);
    localparam int NST = Q_WIDTH;

    logic [LEN_WIDTH:0]   r_reg   [NST][3];
    logic [Q_WIDTH-1:0]   q_reg   [NST][3];
    logic [LEN_WIDTH-1:0] len_reg [NST];
    logic                 dg_reg  [NST];
    vec_t                 vec_reg [NST];
    logic [NST-1:0]       vld_reg;

    logic [MAG_WIDTH-1:0] mags [3];
    assign mags[0] = in_vec.mag_x;
    assign mags[1] = in_vec.mag_y;
    assign mags[2] = in_vec.mag_z;

    genvar g, l;
    generate
        for (g = 0; g < NST; g++) begin : g_stage
            logic [LEN_WIDTH-1:0] len_in;
            logic                 v_in, dg_in;
            vec_t                 vec_in;
            if (g == 0) begin : g_first
                assign len_in = in_len;
                assign v_in   = in_valid;
                assign dg_in  = in_degen;
                assign vec_in = in_vec;
            end else begin : g_rest
                assign len_in = len_reg[g-1];
                assign v_in   = vld_reg[g-1];
                assign dg_in  = dg_reg[g-1];
                assign vec_in = vec_reg[g-1];
            end
            for (l = 0; l < 3; l++) begin : g_lane
                logic [LEN_WIDTH:0]   r_in, r_sh, r_next;
                logic [Q_WIDTH-1:0]   q_in, q_next;
                if (g == 0) begin : g_first
                    logic [LEN_WIDTH-1:0] m_clip;
                    // clip magnitude to the length
                    assign m_clip = ({{(LEN_WIDTH-MAG_WIDTH){1'b0}}, mags[l]} > in_len)
                                    ? in_len
                                    : {{(LEN_WIDTH-MAG_WIDTH){1'b0}}, mags[l]};
                    assign r_in = '0;
                    assign q_in = '0;
                    assign r_sh = {1'b0, m_clip};
                end else begin : g_rest
                    assign r_in = r_reg[g-1][l];
                    assign q_in = q_reg[g-1][l];
                    assign r_sh = {r_in[LEN_WIDTH-1:0], 1'b0};
                end
                always_comb begin
                    r_next = r_sh;
                    q_next = {q_in[Q_WIDTH-2:0], 1'b0};
                    if (r_sh >= {1'b0, len_in} && !dg_in) begin
                        r_next = r_sh - {1'b0, len_in};
                        q_next[0] = 1'b1;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en) begin
                        r_reg[g][l] <= r_next;
                        q_reg[g][l] <= q_next;
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= v_in;
                end
                if (en) begin
                    len_reg[g] <= len_in;
                    dg_reg[g]  <= dg_in;
                    vec_reg[g] <= vec_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NST-1];
    assign out_degen = dg_reg[NST-1];
    assign out_vec   = vec_reg[NST-1];
    assign out_qx    = q_reg[NST-1][0];
    assign out_qy    = q_reg[NST-1][1];
    assign out_qz    = q_reg[NST-1][2];
endmodule

/* hw/rtl/triangle_unit_normal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Exact face normal of a triangle plus its Q1.14 unit vector.
// ----------------------------------------------------------------------------
// Accepts one triangle per cycle unless stalled, returns one word per triangle in order.
// The pipeline is built from four arithmetic stages (edge
// differences, products, cross product with magnitudes, squares), a 34-stage
// square root with one root bit per stage that takes the sum of squares
// straight from the squares stage, a 15-stage divider that forms the three
// quotients in parallel, and the output register. A stall on the result side
// freezes the whole pipeline; nothing is dropped.
module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [THR_WIDTH-1:0]         cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_ax, s_ay, s_az,
    input  logic signed [COORD_WIDTH-1:0] s_bx, s_by, s_bz,
    input  logic signed [COORD_WIDTH-1:0] s_cx, s_cy, s_cz,
    output logic                         m_valid,
    input  logic                         m_ready,
    output raw_t                         m_raw_x, m_raw_y, m_raw_z,
    output logic signed [UNIT_WIDTH-1:0] m_unit_x, m_unit_y, m_unit_z,
    output logic                         m_degenerate
);
    localparam int PW = 2 * DIFF_WIDTH;

    logic [THR_WIDTH-1:0] thr_reg;
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // stage 1: edge vectors
    logic signed [DIFF_WIDTH-1:0] s_reg [3], t_reg [3];
    logic v1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            s_reg[0] <= DIFF_WIDTH'(s_bx) - DIFF_WIDTH'(s_ax);
            s_reg[1] <= DIFF_WIDTH'(s_by) - DIFF_WIDTH'(s_ay);
            s_reg[2] <= DIFF_WIDTH'(s_bz) - DIFF_WIDTH'(s_az);
            t_reg[0] <= DIFF_WIDTH'(s_cx) - DIFF_WIDTH'(s_ax);
            t_reg[1] <= DIFF_WIDTH'(s_cy) - DIFF_WIDTH'(s_ay);
            t_reg[2] <= DIFF_WIDTH'(s_cz) - DIFF_WIDTH'(s_az);
        end
    end

    // stage 2: six products
    logic signed [PW-1:0] p_reg [6];
    logic v2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            p_reg[0] <= s_reg[1] * t_reg[2];
            p_reg[1] <= s_reg[2] * t_reg[1];
            p_reg[2] <= s_reg[2] * t_reg[0];
            p_reg[3] <= s_reg[0] * t_reg[2];
            p_reg[4] <= s_reg[0] * t_reg[1];
            p_reg[5] <= s_reg[1] * t_reg[0];
        end
    end

    // stage 3: cross product and magnitudes
    raw_t n_next [3];
    logic [MAG_WIDTH-1:0] m_next [3];
    always_comb begin
        n_next[0] = p_reg[0] - p_reg[1];
        n_next[1] = p_reg[2] - p_reg[3];
        n_next[2] = p_reg[4] - p_reg[5];
        for (int i = 0; i < 3; i++) begin
            m_next[i] = n_next[i][RAW_WIDTH-1] ? MAG_WIDTH'(-n_next[i])
                                              : MAG_WIDTH'(n_next[i]);
        end
    end
    vec_t v3_vec_reg;
    logic v3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            v3_vec_reg <= '{n_next[0], n_next[1], n_next[2],
                            m_next[0], m_next[1], m_next[2]};
        end
    end

    // stage 4: squares
    logic [2*MAG_WIDTH-1:0] sq_reg [3];
    vec_t v4_vec_reg;
    logic v4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            sq_reg[0]  <= v3_vec_reg.mag_x * v3_vec_reg.mag_x;
            sq_reg[1]  <= v3_vec_reg.mag_y * v3_vec_reg.mag_y;
            sq_reg[2]  <= v3_vec_reg.mag_z * v3_vec_reg.mag_z;
            v4_vec_reg <= v3_vec_reg;
        end
    end

    logic [SUM_WIDTH-1:0] sum;
    assign sum = SUM_WIDTH'(sq_reg[0]) + SUM_WIDTH'(sq_reg[1]) + SUM_WIDTH'(sq_reg[2]);

    logic                 sq_valid;
    logic [LEN_WIDTH-1:0] sq_len;
    vec_t                 sq_vec;
    tun_pipe_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_sum    (sum),
        .in_vec    (v4_vec_reg),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_vec   (sq_vec)
    );

    logic degen;
    assign degen = sq_len <= LEN_WIDTH'(thr_reg);

    logic               dv_valid, dv_degen;
    vec_t               dv_vec;
    logic [Q_WIDTH-1:0] qx, qy, qz;
    tun_pipe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_len),
        .in_degen  (degen),
        .in_vec    (sq_vec),
        .out_valid (dv_valid),
        .out_degen (dv_degen),
        .out_vec   (dv_vec),
        .out_qx    (qx),
        .out_qy    (qy),
        .out_qz    (qz)
    );

    function automatic logic signed [UNIT_WIDTH-1:0] apply_sign(
        input logic [Q_WIDTH-1:0] q, input logic neg, input logic dg);
        logic signed [UNIT_WIDTH-1:0] v;
        v = UNIT_WIDTH'(q);
        if (dg) return '0;
        return neg ? -v : v;
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= dv_valid;
        end
        if (en) begin
            m_raw_x      <= dv_vec.raw_x;
            m_raw_y      <= dv_vec.raw_y;
            m_raw_z      <= dv_vec.raw_z;
            m_unit_x     <= apply_sign(qx, dv_vec.raw_x[RAW_WIDTH-1], dv_degen);
            m_unit_y     <= apply_sign(qy, dv_vec.raw_y[RAW_WIDTH-1], dv_degen);
            m_unit_z     <= apply_sign(qz, dv_vec.raw_z[RAW_WIDTH-1], dv_degen);
            m_degenerate <= dv_degen;
        end
    end
endmodule
